### sv/gskl_pkg.sv
// Package for the symmetric KL distance block: widths, sequencer codes, divider status.
// No dependencies; the multiplier, divider, top level and bench import it.
package gskl_pkg;

	localparam int VAL_W  = 32;                  // mean and variance codes
	localparam int OPD_W  = VAL_W + 1;           // multiplier operand width
	localparam int PRD_W  = 2 * OPD_W;           // multiplier product width
	localparam int DEN_W  = 2 * VAL_W;           // va * vb
	localparam int TERM_W = 48;                  // per-dimension term and running sum
	localparam int CNT_W  = $clog2(TERM_W);      // divider step counter

	localparam logic [TERM_W-1:0] SUM_MAX = '1;

	// sequencer states
	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
	localparam logic [ST_W-1:0] ST_PREP     = 4'd1;
	localparam logic [ST_W-1:0] ST_MUL_DV   = 4'd2;
	localparam logic [ST_W-1:0] ST_MUL_DM   = 4'd3;
	localparam logic [ST_W-1:0] ST_MUL_LO   = 4'd4;
	localparam logic [ST_W-1:0] ST_MUL_HI   = 4'd5;
	localparam logic [ST_W-1:0] ST_MUL_DEN  = 4'd6;
	localparam logic [ST_W-1:0] ST_DIV_GO   = 4'd7;
	localparam logic [ST_W-1:0] ST_DIV_WAIT = 4'd8;
	localparam logic [ST_W-1:0] ST_ACC      = 4'd9;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### sv/gskl_in_if.sv
// Input channel of the symmetric KL distance block: one dimension of both models.
// Depends on nothing.
interface gskl_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] mean_a;
	logic        [31:0] var_a;
	logic signed [31:0] mean_b;
	logic        [31:0] var_b;
	logic               last_dim;

	modport source(output valid, mean_a, var_a, mean_b, var_b, last_dim, input ready);
	modport sink(input valid, mean_a, var_a, mean_b, var_b, last_dim, output ready);
endinterface

### sv/gskl_out_if.sv
// Result channel of the symmetric KL distance block: distance and error flag.
// Depends on nothing.
interface gskl_out_if;
	logic        valid;
	logic        ready;
	logic [47:0] distance;
	logic        error;

	modport source(output valid, distance, error, input ready);
	modport sink(input valid, distance, error, output ready);
endinterface

### sv/gskl_mul.sv
// Shared registered multiplier (unsigned 33 x 33) used by the sequencer for every product.
// Depends on gskl_pkg.
module gskl_mul import gskl_pkg::*; (
	input  logic             clk,
	input  logic [OPD_W-1:0] a,
	input  logic [OPD_W-1:0] b,
	output logic [PRD_W-1:0] prod
);

	logic [PRD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

### sv/gskl_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to TERM_W bits.
// Depends on gskl_pkg.
module gskl_div import gskl_pkg::*; #(
	parameter int NUM_W = 98
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output div_stat_t         stat,
	output logic [TERM_W-1:0] quo
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [TERM_W-1:0] quo_q;

	logic [DEN_W:0]    num_hi;
	logic [DEN_W+1:0]  diff;
	logic              ge;

	// quotient overflows 48 bits exactly when the upper numerator part reaches the divisor
	assign num_hi = (DEN_W+1)'(num[NUM_W-1:TERM_W]);
	assign diff   = {1'b0, rem_q, quo_q[TERM_W-1]} - {2'b00, den_q};
	assign ge     = ~diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (num_hi >= {1'b0, den}) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(TERM_W - 1);
				end
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// hold the divisor for the whole loop
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			if (num_hi >= {1'b0, den}) begin
				quo_q <= SUM_MAX;
			end else begin
				rem_q <= num_hi[DEN_W-1:0];
				quo_q <= num[TERM_W-1:0];
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : {rem_q[DEN_W-2:0], quo_q[TERM_W-1]};
			quo_q <= {quo_q[TERM_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

### sv/gaussian_symmetric_kl_distance_top.sv
// Symmetric KL distance between two diagonal Gaussians, top level with its sequencer.
// Depends on gskl_pkg, gskl_in_if, gskl_out_if, gskl_mul and gskl_div.
//
// Each request on the item channel carries one dimension of both models (mean and
// variance of track A and track B, Q16.FRAC_BITS). The block adds
// ((va-vb)^2*2^F + (ma-mb)^2*(va+vb)) / (va*vb), truncated and saturated to 48 bits,
// to a saturating 48-bit running sum. On the request marked last_dim it places one
// request on the result channel with the sum (or 0 and error = 1 if any variance of
// the vector pair was zero) and clears the sum. From one accepted request to the next, an
// item goes through the accepting cycle, a prepare step, five passes through the shared
// 33 x 33 multiplier, one divider start, the bit-serial divider loop with one step per
// quotient bit, a step to see the divider done and an accumulate step. A term that
// saturates skips the divider loop, and an item with a zero variance skips the arithmetic.
// The item channel is ready only while the sequencer is idle. The result sits in an
// output register, so the next item is taken while a result still waits; only a
// second last item stalls in the accumulate step until the earlier result is taken.
module gaussian_symmetric_kl_distance_top import gskl_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	gskl_in_if.sink    item,
	gskl_out_if.source result
);

	// numerator: (dv^2 << F) + adm^2 * (va + vb), one spare bit for the sum
	localparam int T1_W  = DEN_W + FRAC_BITS;
	localparam int T2_W  = DEN_W + OPD_W;
	localparam int NUM_W = ((T1_W > T2_W) ? T1_W : T2_W) + 1;

	logic [ST_W-1:0]   state_q;

	// captured request
	logic [VAL_W-1:0]  ma_q, va_q, mb_q, vb_q;
	logic              last_q;
	logic              zero_q;

	// prepared operands
	logic [VAL_W-1:0]  adm_q;
	logic [VAL_W-1:0]  dv_q;
	logic [OPD_W-1:0]  vs_q;
	logic [DEN_W-1:0]  a2_q;
	logic [NUM_W-1:0]  num_q;

	// accumulation and result
	logic [TERM_W-1:0] sum_q;
	logic              err_q;
	logic              out_valid_q;
	logic [TERM_W-1:0] out_dist_q;
	logic              out_err_q;

	logic [OPD_W-1:0]  mul_a, mul_b;
	logic [PRD_W-1:0]  prod;
	div_stat_t         div_stat;
	logic [TERM_W-1:0] quo;
	logic              div_start;

	logic signed [VAL_W:0] dm;
	logic [VAL_W:0]        dm_abs;
	logic [TERM_W:0]       sum_ext;
	logic [TERM_W-1:0]     sum_next;
	logic                  err_next;
	logic                  out_free;
	logic                  emit;

	assign item.ready = (state_q == ST_IDLE);
	assign div_start  = (state_q == ST_DIV_GO);
	assign out_free   = ~out_valid_q | result.ready;
	assign emit       = (state_q == ST_ACC) & last_q & out_free;

	assign dm     = $signed({ma_q[VAL_W-1], ma_q}) - $signed({mb_q[VAL_W-1], mb_q});
	assign dm_abs = dm[VAL_W] ? (VAL_W+1)'(-dm) : dm;

	// add the term unless this dimension had a zero variance, then saturate
	assign sum_ext  = {1'b0, sum_q} + {1'b0, (zero_q ? {TERM_W{1'b0}} : quo)};
	assign sum_next = sum_ext[TERM_W] ? SUM_MAX : sum_ext[TERM_W-1:0];
	assign err_next = err_q | zero_q;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL_DV: begin
				mul_a = OPD_W'(dv_q);
				mul_b = OPD_W'(dv_q);
			end
			ST_MUL_DM: begin
				mul_a = OPD_W'(adm_q);
				mul_b = OPD_W'(adm_q);
			end
			ST_MUL_LO: begin
				mul_a = OPD_W'(prod[VAL_W-1:0]);
				mul_b = vs_q;
			end
			ST_MUL_HI: begin
				mul_a = OPD_W'(a2_q[DEN_W-1:VAL_W]);
				mul_b = vs_q;
			end
			ST_MUL_DEN: begin
				mul_a = OPD_W'(va_q);
				mul_b = OPD_W'(vb_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	gskl_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	gskl_div #(.NUM_W(NUM_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (prod[DEN_W-1:0]),
		.stat   (div_stat),
		.quo    (quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q   <= '0;
			err_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						// zero variance: skip the arithmetic
						state_q <= (item.var_a == '0 || item.var_b == '0) ? ST_ACC : ST_PREP;
					end
				end
				ST_PREP:     state_q <= ST_MUL_DV;
				ST_MUL_DV:   state_q <= ST_MUL_DM;
				ST_MUL_DM:   state_q <= ST_MUL_LO;
				ST_MUL_LO:   state_q <= ST_MUL_HI;
				ST_MUL_HI:   state_q <= ST_MUL_DEN;
				ST_MUL_DEN:  state_q <= ST_DIV_GO;
				ST_DIV_GO:   state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_stat.done) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (!last_q) begin
						sum_q   <= sum_next;
						err_q   <= err_next;
						state_q <= ST_IDLE;
					end else if (out_free) begin
						// hand over the result and clear for the next vector pair
						sum_q   <= '0;
						err_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result valid: raise on a new result, drop once the waiting one is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.valid && result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			ma_q   <= item.mean_a;
			va_q   <= item.var_a;
			mb_q   <= item.mean_b;
			vb_q   <= item.var_b;
			last_q <= item.last_dim;
			zero_q <= (item.var_a == '0) || (item.var_b == '0);
		end
		case (state_q)
			ST_PREP: begin
				adm_q <= dm_abs[VAL_W-1:0];
				dv_q  <= (va_q > vb_q) ? (va_q - vb_q) : (vb_q - va_q);
				vs_q  <= {1'b0, va_q} + {1'b0, vb_q};
			end
			ST_MUL_DM:  num_q <= NUM_W'(prod[DEN_W-1:0]) << FRAC_BITS;
			ST_MUL_LO:  a2_q  <= prod[DEN_W-1:0];
			ST_MUL_HI:  num_q <= num_q + NUM_W'(prod);
			ST_MUL_DEN: num_q <= num_q + (NUM_W'(prod) << VAL_W);
			default: begin
			end
		endcase
		if (emit) begin
			out_dist_q <= err_next ? {TERM_W{1'b0}} : sum_next;
			out_err_q  <= err_next;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.distance = out_dist_q;
	assign result.error    = out_err_q;

	// a new result appears only from the accumulate step of a last item
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_ACC && $past(last_q))
		else $error("result raised outside the accumulate step of a last item");

	// an error result carries a zero distance
	a_err_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_err_q |-> out_dist_q == '0)
		else $error("error result with nonzero distance");

	// the divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV_WAIT)
		else $error("divider done outside the wait step");

	// the divider is never restarted while it runs
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// emitting a result clears the running state
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> sum_q == '0 && !err_q && state_q == ST_IDLE)
		else $error("running sum not cleared after a result");

endmodule

### verif/gaussian_symmetric_kl_distance_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for gaussian_symmetric_kl_distance_top: drives dimension requests,
// predicts each distance in a small ledger class and checks every result request.
// Depends on gskl_pkg, gskl_in_if, gskl_out_if and the block itself.
module gaussian_symmetric_kl_distance_top_tb import gskl_pkg::*; ();

	localparam int FRAC       = 16;
	localparam int QUIET_MAX  = 5000;  // cycles with no handshake before giving up
	localparam int HOLD_OFF   = 600;   // long result stall that backs the block up
	localparam int RAND_ITEMS = 1600;
	localparam logic [31:0] ONE = 32'h0001_0000;

	typedef struct {
		logic [47:0] distance;
		logic        error;
	} kl_result_t;

	// Running sum and zero-variance flag mirror the block; finished vector pairs
	// wait in pending until their result request shows up.
	class kl_ledger;
		kl_result_t  pending[$];
		logic [47:0] sum;
		logic        seen_zero_var;
		int          mismatches;

		function new();
			sum = '0;
			seen_zero_var = 1'b0;
			mismatches = 0;
		endfunction

		task report(string what);
			$display("%0t ns: mismatch: %s", $time, what);
			mismatches++;
		endtask

		// floor(((va-vb)^2*2^F + (ma-mb)^2*(va+vb)) / (va*vb)), saturated to 48 bits
		function logic [47:0] dim_term(logic signed [31:0] ma, logic [31:0] va,
				logic signed [31:0] mb, logic [31:0] vb);
			logic signed [32:0] dm;
			logic [32:0]        adm;
			logic [31:0]        dv;
			logic [127:0]       num;
			logic [127:0]       quo;
			logic [63:0]        den;
			dm  = {ma[31], ma} - {mb[31], mb};
			adm = dm[32] ? -dm : dm;
			dv  = (va > vb) ? va - vb : vb - va;
			num = (128'(dv) * 128'(dv)) << FRAC;
			num = num + 128'(adm) * 128'(adm) * (128'(va) + 128'(vb));
			den = 64'(va) * 64'(vb);
			quo = num / 128'(den);
			return (quo > 128'(SUM_MAX)) ? SUM_MAX : quo[47:0];
		endfunction

		function void take_dimension(logic signed [31:0] ma, logic [31:0] va,
				logic signed [31:0] mb, logic [31:0] vb, logic last);
			logic [48:0] acc;
			kl_result_t  r;
			if (va == '0 || vb == '0) begin
				seen_zero_var = 1'b1;
			end else begin
				acc = {1'b0, sum} + {1'b0, dim_term(ma, va, mb, vb)};
				sum = acc[48] ? SUM_MAX : acc[47:0];
			end
			if (last) begin
				r.error    = seen_zero_var;
				r.distance = seen_zero_var ? '0 : sum;
				pending.insert(pending.size(), r);
				sum = '0;
				seen_zero_var = 1'b0;
			end
		endfunction

		task check_distance(logic [47:0] distance, logic error);
			kl_result_t r;
			if (pending.size() == 0) begin
				report($sformatf("result with nothing pending: distance %h error %b",
					distance, error));
			end else begin
				r = pending.pop_front();
				if (distance !== r.distance)
					report($sformatf("distance %h, predicted %h", distance, r.distance));
				if (error !== r.error)
					report($sformatf("error flag %b, predicted %b", error, r.error));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	gskl_in_if  item_if();
	gskl_out_if result_if();

	gaussian_symmetric_kl_distance_top #(.FRAC_BITS(FRAC)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	kl_ledger book = new();

	bit steady;         // both sides skip idling while set
	bit hold_request;   // ask the result side for one long stall
	int random_items;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// note accepted dimension requests
	always @(posedge clk) begin
		if (arst_n && item_if.valid && item_if.ready)
			book.take_dimension(item_if.mean_a, item_if.var_a, item_if.mean_b,
				item_if.var_b, item_if.last_dim);
	end

	// check accepted result requests
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready)
			book.check_distance(result_if.distance, result_if.error);
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				result_if.ready <= 1'b0;
				repeat (HOLD_OFF) @(negedge clk);
			end
			result_if.ready <= steady || ($urandom_range(99) >= 27);
		end
	end

	// give up when no request moves on either channel for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_MAX) begin
			@(posedge clk);
			if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("gaussian_symmetric_kl_distance_top_tb: errors");
		$finish;
	end

	// Offer one dimension request; hold it until the block takes it.
	task automatic send_dim(logic signed [31:0] ma, logic [31:0] va,
			logic signed [31:0] mb, logic [31:0] vb, logic last);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 27) begin
			item_if.valid <= 1'b0;
			@(negedge clk);
		end
		item_if.valid    <= 1'b1;
		item_if.mean_a   <= ma;
		item_if.var_a    <= va;
		item_if.mean_b   <= mb;
		item_if.var_b    <= vb;
		item_if.last_dim <= last;
		do @(posedge clk); while (!item_if.ready);
	endtask

	function automatic logic [31:0] pick_variance();
		if ($urandom_range(39) == 0)
			return '0;
		case ($urandom_range(7))
			0: return $urandom;
			1: return $urandom_range(1, 255);
			2, 3, 4: return $urandom_range(32'h0000_1000, 32'h0010_0000);
			5: return 32'hFFFF_FFFF - $urandom_range(255);
			6: return ONE;
			default: return $urandom_range(32'h0000_0100, 32'h0100_0000);
		endcase
	endfunction

	function automatic logic signed [31:0] pick_mean();
		case ($urandom_range(5))
			0, 1: return $urandom;
			2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			3: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
			default: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
		endcase
	endfunction

	// One vector pair of random content, last_dim on its final dimension.
	task automatic send_vector(int dims);
		for (int d = 0; d < dims; d++)
			send_dim(pick_mean(), pick_variance(), pick_mean(), pick_variance(),
				d == dims - 1);
		random_items += dims;
	endtask

	initial begin
		bit pressure_done;
		int dims;
		pressure_done = 1'b0;
		steady        = 1'b0;
		hold_request  = 1'b0;
		random_items  = 0;
		item_if.valid    = 1'b0;
		item_if.mean_a   = '0;
		item_if.var_a    = '0;
		item_if.mean_b   = '0;
		item_if.var_b    = '0;
		item_if.last_dim = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single dimensions: identical models, an ordinary pair, extremes
		send_dim(0, ONE, 0, ONE, 1'b1);
		send_dim(32'sh0002_0000, ONE, -32'sh0001_0000, 32'h0002_0000, 1'b1);
		send_dim(32'sh7FFF_FFFF, 32'h1, 32'sh8000_0000, 32'h1, 1'b1);
		send_dim(32'sh8000_0000, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_dim(0, 32'hFFFF_FFFF, 0, 32'h1, 1'b1);
		send_dim(-32'sh1, 32'h8000_0000, 32'sh1, 32'h7FFF_FFFF, 1'b1);
		// zero variance on either side and on both
		send_dim(0, 32'h0, 0, ONE, 1'b1);
		send_dim(0, ONE, 0, 32'h0, 1'b1);
		send_dim(32'sh5, 32'h0, -32'sh5, 32'h0, 1'b1);
		// zero variance mid-vector, then a clean pair must start from a cleared sum
		send_dim(0, 32'h0, 0, ONE, 1'b0);
		send_dim(ONE, ONE, 0, ONE, 1'b0);
		send_dim(0, ONE, 0, 32'h0002_0000, 1'b1);
		send_dim(ONE, ONE, 0, ONE, 1'b1);
		// each term is 2^47, so the sum saturates on the second dimension
		send_dim(32'sh4000_0000, ONE, -32'sh4000_0000, ONE, 1'b0);
		send_dim(32'sh4000_0000, ONE, -32'sh4000_0000, ONE, 1'b0);
		send_dim(32'sh4000_0000, ONE, -32'sh4000_0000, ONE, 1'b1);
		// ordinary multi-dimension pair
		send_dim(32'sh0000_8000, 32'h0000_4000, 32'sh0001_0000, 32'h0003_0000, 1'b0);
		send_dim(-32'sh0003_0000, 32'h0001_8000, 32'sh0000_2000, 32'h0000_C000, 1'b0);
		send_dim(32'sh0010_0000, 32'h00FF_0000, 32'sh0010_0000, 32'h00FF_0000, 1'b1);

		// random pairs: an unbroken stretch in the middle, one long result stall
		while (random_items < RAND_ITEMS) begin
			steady = (random_items >= 500 && random_items < 800);
			if (!pressure_done && random_items >= 1000) begin
				hold_request  = 1'b1;
				pressure_done = 1'b1;
			end
			dims = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
			send_vector(dims);
		end
		steady = 1'b0;
		@(negedge clk);
		item_if.valid <= 1'b0;

		// drain, then allow the divider latency for anything unexpected
		while (book.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (book.pending.size() != 0)
			book.report($sformatf("%0d results never arrived", book.pending.size()));

		if (book.mismatches == 0)
			$display("gaussian_symmetric_kl_distance_top_tb: clean");
		else
			$display("gaussian_symmetric_kl_distance_top_tb: errors");
		$finish;
	end

endmodule

### files.f
sv/gskl_pkg.sv
sv/gskl_in_if.sv
sv/gskl_out_if.sv
sv/gskl_mul.sv
sv/gskl_div.sv
sv/gaussian_symmetric_kl_distance_top.sv
verif/gaussian_symmetric_kl_distance_top_tb.sv
